// ===== hw/rtl/cau_pkg.sv =====
package cau_pkg;

  // Default operand format: signed Q16.16.
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_EQ  = 3'd4
  } cmd_e;

endpackage

// ===== hw/rtl/complex_arith_unit.sv =====
// Channel | Direction | Handshake          | Payload
// input   | in        | valid_i / stall_o  | command_i, a_re_i, a_im_i, b_re_i, b_im_i
// output  | out       | valid_o / stall_i  | res_re_o, res_im_o, is_equal_o, div_zero_o,
//         |           |                    | overflow_o
//
// One beat enters per cycle unless the output stalls; every command passes
// stages 1 to 3, the divider entry stage, the divider stages, which resolve one
// quotient bit per stage, and the output register, in that order.
// Reset clears only the valid bits of the pipeline; payload registers are not reset.
// A waiting output beat that is stalled freezes the whole pipeline, so no
// beat is lost or repeated; bubbles keep moving while the output is empty.
module complex_arith_unit #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic [2:0]                   command_i,
  input  logic signed [DATA_WIDTH-1:0] a_re_i,
  input  logic signed [DATA_WIDTH-1:0] a_im_i,
  input  logic signed [DATA_WIDTH-1:0] b_re_i,
  input  logic signed [DATA_WIDTH-1:0] b_im_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic signed [DATA_WIDTH-1:0] res_re_o,
  output logic signed [DATA_WIDTH-1:0] res_im_o,
  output logic                         is_equal_o,
  output logic                         div_zero_o,
  output logic                         overflow_o
);
  import cau_pkg::*;

  localparam int DW     = DATA_WIDTH;
  localparam int PW     = 2 * DW;          // one partial product
  localparam int SW     = PW + 1;          // sum of two products
  localparam int NW     = SW + FRAC_BITS;  // scaled dividend magnitude
  localparam int QB     = DW + 1;          // quotient bits kept
  localparam int SIDE_W = 2 * DW + 6;

  // Saturate a signed sum one bit wider than the result. Returns {ovf, value}.
  function automatic logic [DW:0] sat_sum(input logic signed [DW:0] s);
    logic [DW:0] r;
    r = {1'b0, s[DW-1:0]};
    if (s[DW] != s[DW-1]) begin
      r = {1'b1, s[DW], {(DW-1){~s[DW]}}};
    end
    return r;
  endfunction

  // Saturate a sign and magnitude pair to the signed range. Returns {ovf, value}.
  function automatic logic [DW:0] sat_mag(input logic [SW-1:0] m, input logic neg);
    logic [SW-1:0] lim;
    logic [SW-1:0] mm;
    logic          ov;
    logic [DW-1:0] v;
    lim = neg ? (SW'(1) << (DW - 1)) : ((SW'(1) << (DW - 1)) - SW'(1));
    ov  = m > lim;
    mm  = ov ? lim : m;
    v   = neg ? DW'(~mm + SW'(1)) : DW'(mm);
    return {ov, v};
  endfunction

  // The whole pipeline advances unless a finished beat is held at the output.
  logic en;
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  // Stage 1: the six products, the saturated sum or difference, and the equality test.
  cmd_e              cmd_in;
  logic signed [DW:0] sum_re, sum_im;
  logic [DW:0]        sat_re, sat_im;
  assign cmd_in = cmd_e'(command_i);
  assign sum_re = (cmd_in == CMD_SUB) ? (DW+1)'(a_re_i) - (DW+1)'(b_re_i)
                                      : (DW+1)'(a_re_i) + (DW+1)'(b_re_i);
  assign sum_im = (cmd_in == CMD_SUB) ? (DW+1)'(a_im_i) - (DW+1)'(b_im_i)
                                      : (DW+1)'(a_im_i) + (DW+1)'(b_im_i);
  assign sat_re = sat_sum(sum_re);
  assign sat_im = sat_sum(sum_im);

  logic               v1_q;
  cmd_e               cmd1_q;
  logic signed [PW-1:0] prr1_q, pii1_q, pri1_q, pir1_q, sqr1_q, sqi1_q;
  logic [DW-1:0]      adre1_q, adim1_q;
  logic               adov1_q, eq1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd1_q  <= cmd_in;
      prr1_q  <= PW'(a_re_i) * PW'(b_re_i);
      pii1_q  <= PW'(a_im_i) * PW'(b_im_i);
      pri1_q  <= PW'(a_re_i) * PW'(b_im_i);
      pir1_q  <= PW'(a_im_i) * PW'(b_re_i);
      sqr1_q  <= PW'(b_re_i) * PW'(b_re_i);
      sqi1_q  <= PW'(b_im_i) * PW'(b_im_i);
      adre1_q <= sat_re[DW-1:0];
      adim1_q <= sat_im[DW-1:0];
      adov1_q <= sat_re[DW] | sat_im[DW];
      eq1_q   <= (a_re_i == b_re_i) && (a_im_i == b_im_i);
    end
  end

  // Stage 2: combine products. Division uses the conjugate of the divisor.
  logic               v2_q;
  cmd_e               cmd2_q;
  logic signed [SW-1:0] sre2_q, sim2_q;
  logic [SW-1:0]      den2_q;
  logic [DW-1:0]      adre2_q, adim2_q;
  logic               adov2_q, eq2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd2_q  <= cmd1_q;
      if (cmd1_q == CMD_DIV) begin
        sre2_q <= SW'(prr1_q) + SW'(pii1_q);
        sim2_q <= SW'(pir1_q) - SW'(pri1_q);
      end else begin
        sre2_q <= SW'(prr1_q) - SW'(pii1_q);
        sim2_q <= SW'(pri1_q) + SW'(pir1_q);
      end
      den2_q  <= SW'($unsigned(sqr1_q)) + SW'($unsigned(sqi1_q));
      adre2_q <= adre1_q;
      adim2_q <= adim1_q;
      adov2_q <= adov1_q;
      eq2_q   <= eq1_q;
    end
  end

  // Stage 3: sign and magnitude, product scaling and saturation, and the
  // result of every command that does not divide.
  logic          neg_re, neg_im;
  logic [SW-1:0] mag_re, mag_im;
  logic [DW:0]   mul_re, mul_im;
  logic [DW-1:0] s3_re, s3_im;
  logic          s3_eq, s3_ov, s3_div, s3_dz;

  assign neg_re = sre2_q[SW-1];
  assign neg_im = sim2_q[SW-1];
  assign mag_re = neg_re ? SW'(-sre2_q) : SW'(sre2_q);
  assign mag_im = neg_im ? SW'(-sim2_q) : SW'(sim2_q);
  assign mul_re = sat_mag(mag_re >> FRAC_BITS, neg_re);
  assign mul_im = sat_mag(mag_im >> FRAC_BITS, neg_im);
  assign s3_dz  = (den2_q == '0);

  always_comb begin
    s3_re  = '0;
    s3_im  = '0;
    s3_eq  = 1'b0;
    s3_ov  = 1'b0;
    s3_div = 1'b0;
    case (cmd2_q)
      CMD_ADD, CMD_SUB: begin
        s3_re = adre2_q;
        s3_im = adim2_q;
        s3_ov = adov2_q;
      end
      CMD_MUL: begin
        s3_re = mul_re[DW-1:0];
        s3_im = mul_im[DW-1:0];
        s3_ov = mul_re[DW] | mul_im[DW];
      end
      CMD_DIV: begin
        s3_div = 1'b1;
      end
      CMD_EQ: begin
        s3_eq = eq2_q;
      end
      default: begin
        s3_re = '0;
      end
    endcase
  end

  logic              v3_q;
  logic [NW-1:0]     nre3_q, nim3_q;
  logic [SW-1:0]     den3_q;
  logic [SIDE_W-1:0] side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nre3_q  <= NW'(mag_re) << FRAC_BITS;
      nim3_q  <= NW'(mag_im) << FRAC_BITS;
      den3_q  <= den2_q;
      side3_q <= {neg_re, neg_im, s3_dz, s3_div, s3_re, s3_im, s3_eq, s3_ov};
    end
  end

  // Divider stages; every beat passes through them so order is kept.
  logic              vd;
  logic [QB-1:0]     qre, qim;
  logic              bre, bim;
  logic [SIDE_W-1:0] sided;

  cau_div #(
    .NUM_W  (NW),
    .DEN_W  (SW),
    .QB     (QB),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (v3_q),
    .num_re_i (nre3_q),
    .num_im_i (nim3_q),
    .den_i    (den3_q),
    .side_i   (side3_q),
    .valid_o  (vd),
    .q_re_o   (qre),
    .q_im_o   (qim),
    .big_re_o (bre),
    .big_im_o (bim),
    .side_o   (sided)
  );

  // Output stage: saturate the quotient, or pass the result carried alongside.
  logic          d_nre, d_nim, d_dz, d_div, d_eq, d_ov;
  logic [DW-1:0] d_re, d_im;
  logic [DW:0]   qs_re, qs_im;

  assign {d_nre, d_nim, d_dz, d_div, d_re, d_im, d_eq, d_ov} = sided;
  // A quotient known to be too large is forced to a magnitude above the limit.
  assign qs_re = sat_mag(bre ? '1 : SW'(qre), d_nre);
  assign qs_im = sat_mag(bim ? '1 : SW'(qim), d_nim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      is_equal_o <= d_eq;
      if (d_div && d_dz) begin
        res_re_o   <= '0;
        res_im_o   <= '0;
        div_zero_o <= 1'b1;
        overflow_o <= 1'b0;
      end else if (d_div) begin
        res_re_o   <= qs_re[DW-1:0];
        res_im_o   <= qs_im[DW-1:0];
        div_zero_o <= 1'b0;
        overflow_o <= qs_re[DW] | qs_im[DW];
      end else begin
        res_re_o   <= d_re;
        res_im_o   <= d_im;
        div_zero_o <= 1'b0;
        overflow_o <= d_ov;
      end
    end
  end

`ifndef SYNTHESIS
  // A zero divisor never also reports saturation.
  a_dz_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(div_zero_o && overflow_o))
    else $error("div_zero and overflow both set");

  // An equality result carries zero parts and no other flag.
  a_eq_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && is_equal_o) |-> (res_re_o == '0 && res_im_o == '0 &&
                                 !div_zero_o && !overflow_o))
    else $error("equality result not clean");

  // A zero divisor gives a zero result.
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && div_zero_o) |-> (res_re_o == '0 && res_im_o == '0 && !is_equal_o))
    else $error("zero divisor result not zero");

  // The pipeline only holds while a beat waits at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o)
    else $error("input stalled without a waiting output beat");
`endif

endmodule

// ===== hw/rtl/cau_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for two numerators
// that share one divisor.
module cau_div #(
  parameter int NUM_W  = 81,
  parameter int DEN_W  = 65,
  parameter int QB     = 33,
  parameter int SIDE_W = 70
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_re_i,
  input  logic [NUM_W-1:0]  num_im_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QB-1:0]     q_re_o,
  output logic [QB-1:0]     q_im_o,
  output logic              big_re_o,
  output logic              big_im_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int CW = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;

  logic              v_q    [QB+1];
  logic [CW-1:0]     rre_q  [QB+1];
  logic [CW-1:0]     rim_q  [QB+1];
  logic [DEN_W-1:0]  d_q    [QB+1];
  logic [QB-1:0]     qre_q  [QB+1];
  logic [QB-1:0]     qim_q  [QB+1];
  logic              bre_q  [QB+1];
  logic              bim_q  [QB+1];
  logic [SIDE_W-1:0] side_q [QB+1];

  logic [CW-1:0] dtop;
  assign dtop = CW'(den_i) << QB;

  // Entry stage: a numerator at or above the divisor shifted past the kept
  // quotient bits can only saturate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rre_q[0]  <= CW'(num_re_i);
      rim_q[0]  <= CW'(num_im_i);
      d_q[0]    <= den_i;
      qre_q[0]  <= '0;
      qim_q[0]  <= '0;
      bre_q[0]  <= CW'(num_re_i) >= dtop;
      bim_q[0]  <= CW'(num_im_i) >= dtop;
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_stage
    localparam int SH = QB - s;
    logic [CW-1:0] dsh;
    logic          take_re, take_im;
    assign dsh     = CW'(d_q[s-1]) << SH;
    assign take_re = rre_q[s-1] >= dsh;
    assign take_im = rim_q[s-1] >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rre_q[s]  <= take_re ? rre_q[s-1] - dsh : rre_q[s-1];
        rim_q[s]  <= take_im ? rim_q[s-1] - dsh : rim_q[s-1];
        d_q[s]    <= d_q[s-1];
        qre_q[s]  <= qre_q[s-1] | (QB'(take_re) << SH);
        qim_q[s]  <= qim_q[s-1] | (QB'(take_im) << SH);
        bre_q[s]  <= bre_q[s-1];
        bim_q[s]  <= bim_q[s-1];
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o  = v_q[QB];
  assign q_re_o   = qre_q[QB];
  assign q_im_o   = qim_q[QB];
  assign big_re_o = bre_q[QB];
  assign big_im_o = bim_q[QB];
  assign side_o   = side_q[QB];

endmodule
